// ===== design/tfr_pkg.sv =====
`default_nettype none

package tfr_pkg;

   // field widths of one request and one result
   localparam int TIME_W      = 64;
   localparam int PAYLOAD_W   = 56;
   localparam int COUNT_OUT_W = 11;

   // operation carried from the front to the back
   typedef enum logic {
      OP_APPEND = 1'b0,
      OP_LOOKUP = 1'b1
   } op_type;

   // one classified request as it waits in the queue
   typedef struct packed {
      op_type               op;
      logic [TIME_W-1:0]    time_stamp;
      logic [PAYLOAD_W-1:0] payload;
   } cmd_type;

endpackage

`default_nettype wire

// ===== design/tfr_front.sv =====
`default_nettype none

module tfr_front
   import tfr_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_cmd,
   input  wire logic [TIME_W-1:0]    req_time_stamp,
   input  wire logic [PAYLOAD_W-1:0] req_frame_payload,
   output logic                      push_valid,
   input  wire logic                 push_ready,
   output cmd_type                   push_cmd
);

   logic    hold_valid_ff, hold_valid_in;
   cmd_type hold_ff, hold_in;
   logic    take;

   // the holding stage frees up whenever the queue takes its request
   assign req_ready  = !hold_valid_ff || push_ready;
   assign take       = req_valid && req_ready;
   assign push_valid = hold_valid_ff;
   assign push_cmd   = hold_ff;

   // classify the incoming request
   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      if (push_valid && push_ready) begin
         hold_valid_in = 1'b0;
      end
      if (take) begin
         hold_valid_in      = 1'b1;
         hold_in.op         = req_cmd ? OP_LOOKUP : OP_APPEND;
         hold_in.time_stamp = req_time_stamp;
         hold_in.payload    = req_frame_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_ff <= hold_in;
   end

endmodule

`default_nettype wire

// ===== design/tfr_queue.sv =====
`default_nettype none

module tfr_queue
   import tfr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push_valid,
   output logic         push_ready,
   input  wire cmd_type push_cmd,
   output logic         pop_valid,
   input  wire logic    pop_ready,
   output cmd_type      pop_cmd
);

   localparam int ENTRIES = 2;

   cmd_type    slot_ff [ENTRIES];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_push, do_pop;

   assign push_ready = (fill_ff != 2'(ENTRIES));
   assign pop_valid  = (fill_ff != 2'd0);
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== design/tfr_back.sv =====
`default_nettype none

module tfr_back
   import tfr_pkg::*;
#(
   parameter int DEPTH = 1024
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   pop_valid,
   output logic                        pop_ready,
   input  wire cmd_type                pop_cmd,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic                        rsp_frame_found,
   output logic [PAYLOAD_W-1:0]        rsp_found_payload,
   output logic                        rsp_was_stored,
   output logic                        rsp_store_full,
   output logic [COUNT_OUT_W-1:0]      rsp_entry_count
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
   localparam logic [CW-1:0] ONE_C   = CW'(1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_CHECK,
      S_CMP,
      S_PAY
   } state_type;

   // frame memories
   logic [TIME_W-1:0]    time_mem [DEPTH];
   logic [PAYLOAD_W-1:0] pay_mem  [DEPTH];
   logic [TIME_W-1:0]    time_rd_ff;
   logic [PAYLOAD_W-1:0] pay_rd_ff;

   state_type            state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        lo_ff, lo_in;
   logic [CW-1:0]        hi_ff, hi_in;
   logic [CW-1:0]        mid_ff, mid_in;
   logic [TIME_W-1:0]    query_ff, query_in;
   logic [PAYLOAD_W-1:0] last_pay_ff, last_pay_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 found_ff, found_in;
   logic [PAYLOAD_W-1:0] fpay_ff, fpay_in;
   logic                 stored_ff, stored_in;
   logic                 full_ff, full_in;
   logic [CW-1:0]        rcount_ff, rcount_in;

   logic                 out_free;
   logic                 take;
   logic                 wants;
   logic                 mem_we;
   logic                 time_rd_en;
   logic                 pay_rd_en;
   logic [CW:0]          sum;
   logic [CW-1:0]        mid;
   logic [CW-1:0]        span;
   logic [CW+COUNT_OUT_W-1:0] count_ext;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pop_ready = (state_ff == S_IDLE) && out_free;
   assign take      = pop_valid && pop_ready;
   assign wants     = (count_ff == '0) || (last_pay_ff != pop_cmd.payload);
   assign sum       = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid       = sum[CW:1];
   assign span      = hi_ff - lo_ff;

   // next state of the search sequencer and the result register
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      query_in     = query_ff;
      last_pay_in  = last_pay_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      found_in     = found_ff;
      fpay_in      = fpay_ff;
      stored_in    = stored_ff;
      full_in      = full_ff;
      rcount_in    = rcount_ff;
      mem_we       = 1'b0;
      time_rd_en   = 1'b0;
      pay_rd_en    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (take) begin
               unique case (pop_cmd.op)
                  OP_APPEND: begin
                     rsp_valid_in = 1'b1;
                     found_in     = 1'b0;
                     fpay_in      = '0;
                     stored_in    = 1'b0;
                     full_in      = 1'b0;
                     rcount_in    = count_ff;
                     if (wants && (count_ff == DEPTH_C)) begin
                        full_in = 1'b1;
                     end else if (wants) begin
                        mem_we      = 1'b1;
                        count_in    = count_ff + ONE_C;
                        rcount_in   = count_ff + ONE_C;
                        last_pay_in = pop_cmd.payload;
                        stored_in   = 1'b1;
                     end
                  end
                  OP_LOOKUP: begin
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        found_in     = 1'b0;
                        fpay_in      = '0;
                        stored_in    = 1'b0;
                        full_in      = 1'b0;
                        rcount_in    = count_ff;
                     end else begin
                        lo_in    = '0;
                        hi_in    = count_ff;
                        query_in = pop_cmd.time_stamp;
                        state_in = S_CHECK;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_CHECK: begin
            if (span > ONE_C) begin
               mid_in     = mid;
               time_rd_en = 1'b1;
               state_in   = S_CMP;
            end else begin
               pay_rd_en = 1'b1;
               state_in  = S_PAY;
            end
         end
         S_CMP: begin
            if (time_rd_ff > query_ff) begin
               hi_in = mid_ff;
            end else begin
               lo_in = mid_ff;
            end
            state_in = S_CHECK;
         end
         S_PAY: begin
            rsp_valid_in = 1'b1;
            found_in     = 1'b1;
            fpay_in      = pay_rd_ff;
            stored_in    = 1'b0;
            full_in      = 1'b0;
            rcount_in    = count_ff;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      query_ff    <= query_in;
      last_pay_ff <= last_pay_in;
      found_ff    <= found_in;
      fpay_ff     <= fpay_in;
      stored_ff   <= stored_in;
      full_ff     <= full_in;
      rcount_ff   <= rcount_in;
   end

   // one write and one registered read per memory and cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         time_mem[count_ff[IW-1:0]] <= pop_cmd.time_stamp;
         pay_mem[count_ff[IW-1:0]]  <= pop_cmd.payload;
      end
      if (time_rd_en) begin
         time_rd_ff <= time_mem[mid[IW-1:0]];
      end
      if (pay_rd_en) begin
         pay_rd_ff <= pay_mem[lo_ff[IW-1:0]];
      end
   end

   assign count_ext         = {{COUNT_OUT_W{1'b0}}, rcount_ff};
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_found   = found_ff;
   assign rsp_found_payload = fpay_ff;
   assign rsp_was_stored    = stored_ff;
   assign rsp_store_full    = full_ff;
   assign rsp_entry_count   = count_ext[COUNT_OUT_W-1:0];

`ifndef ASSERT_OFF
   // the fill count never passes the store depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("entry count beyond depth");

   // the search window never collapses while a lookup is running
   a_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK || state_ff == S_CMP) |-> (hi_ff > lo_ff))
      else $error("search window empty");

   // the window stays inside the filled part of the store
   a_window_top: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK) |-> (hi_ff <= count_ff))
      else $error("search window beyond fill count");

   // an append result is never both stored and full, and no result is both found and stored
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(stored_ff && full_ff) && !(found_ff && stored_ff))
      else $error("conflicting result flags");

   // a request taken from the queue comes only with room for its result
   a_take_room: assert property (@(posedge clock) disable iff (reset)
      take |-> out_free)
      else $error("request taken while result pending");
`endif

endmodule

`default_nettype wire

// ===== design/timed_frame_recorder_core.sv =====
`default_nettype none

// channel  direction  handshake              payload
// req      in         req_valid / req_ready  req_cmd, req_time_stamp, req_frame_payload
// rsp      out        rsp_valid / rsp_ready  rsp_frame_found, rsp_found_payload,
//                                            rsp_was_stored, rsp_store_full,
//                                            rsp_entry_count
//
// an accepted append passes the holding stage and the queue before it reaches the result register
// a lookup makes one pass through S_CHECK and S_CMP for each halving step, a sequence
// set by the single read port of the time memory and the compare on its registered data
// reset clears the entry count and all handshake state; the memories need no clearing pass
// a two-entry queue between front and back keeps requests flowing while a result waits

module timed_frame_recorder_core
   import tfr_pkg::*;
#(
   parameter int DEPTH = 1024
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   req_cmd,
   input  wire logic [TIME_W-1:0]      req_time_stamp,
   input  wire logic [PAYLOAD_W-1:0]   req_frame_payload,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic                        rsp_frame_found,
   output logic [PAYLOAD_W-1:0]        rsp_found_payload,
   output logic                        rsp_was_stored,
   output logic                        rsp_store_full,
   output logic [COUNT_OUT_W-1:0]      rsp_entry_count
);

   logic    push_valid, push_ready;
   cmd_type push_cmd;
   logic    pop_valid, pop_ready;
   cmd_type pop_cmd;

   // accept and classify requests
   tfr_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_time_stamp    (req_time_stamp),
      .req_frame_payload (req_frame_payload),
      .push_valid        (push_valid),
      .push_ready        (push_ready),
      .push_cmd          (push_cmd)
   );

   // decoupling queue
   tfr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   // store, search and result register
   tfr_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .pop_valid         (pop_valid),
      .pop_ready         (pop_ready),
      .pop_cmd           (pop_cmd),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_frame_found   (rsp_frame_found),
      .rsp_found_payload (rsp_found_payload),
      .rsp_was_stored    (rsp_was_stored),
      .rsp_store_full    (rsp_store_full),
      .rsp_entry_count   (rsp_entry_count)
   );

endmodule

`default_nettype wire

// ===== test/timed_frame_recorder_core_test.sv =====
`default_nettype none

module timed_frame_recorder_core_test
   import tfr_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH       = 1024;
   localparam int STALL_LIMIT = 4000;
   localparam int DRAIN_TAIL  = 40;

   // one result as the block should present it
   typedef struct packed {
      logic                   found;
      logic [PAYLOAD_W-1:0]   payload;
      logic                   stored;
      logic                   full;
      logic [COUNT_OUT_W-1:0] count;
   } recorder_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic                   req_cmd = 1'b0;
   logic [TIME_W-1:0]      req_time_stamp = '0;
   logic [PAYLOAD_W-1:0]   req_frame_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic                   rsp_frame_found;
   logic [PAYLOAD_W-1:0]   rsp_found_payload;
   logic                   rsp_was_stored;
   logic                   rsp_store_full;
   logic [COUNT_OUT_W-1:0] rsp_entry_count;

   // shadow copy of the recorder contents
   logic [TIME_W-1:0]      shadow_times [DEPTH];
   logic [PAYLOAD_W-1:0]   shadow_payloads [DEPTH];
   int unsigned            shadow_count = 0;

   recorder_result_type    pending_outcomes [$];
   int                     failures = 0;
   int                     stall_cycles = 0;
   int                     sender_idle_pct = 0;
   int                     receiver_stall_pct = 0;
   logic [TIME_W-1:0]      next_time = 64'd1000;

   timed_frame_recorder_core #(
      .DEPTH(DEPTH)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_time_stamp    (req_time_stamp),
      .req_frame_payload (req_frame_payload),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_frame_found   (rsp_frame_found),
      .rsp_found_payload (rsp_found_payload),
      .rsp_was_stored    (rsp_was_stored),
      .rsp_store_full    (rsp_store_full),
      .rsp_entry_count   (rsp_entry_count)
   );

   // clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // work out the result of one request and update the shadow contents
   function automatic recorder_result_type recorder_outcome(input op_type op,
                                                            input logic [TIME_W-1:0] stamp,
                                                            input logic [PAYLOAD_W-1:0] frame);
      recorder_result_type res;
      int unsigned         lo;
      int unsigned         hi;
      int unsigned         mid;
      res = '0;
      if (op == OP_APPEND) begin
         // duplicate of the last frame changes nothing
         if (shadow_count == 0 || shadow_payloads[shadow_count - 1] != frame) begin
            if (shadow_count >= DEPTH) begin
               res.full = 1'b1;
            end else begin
               shadow_times[shadow_count]    = stamp;
               shadow_payloads[shadow_count] = frame;
               shadow_count++;
               res.stored = 1'b1;
            end
         end
      end else if (shadow_count != 0) begin
         // binary search for the last entry not after the query, or the first entry if all are after it
         lo = 0;
         hi = shadow_count;
         while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if (shadow_times[mid] > stamp) hi = mid;
            else lo = mid;
         end
         res.found   = 1'b1;
         res.payload = shadow_payloads[lo];
      end
      res.count = COUNT_OUT_W'(shadow_count);
      return res;
   endfunction

   // predict on every accepted request
   always @(posedge clock) begin
      recorder_result_type new_res;
      if (!reset && req_valid && req_ready) begin
         new_res = recorder_outcome(op_type'(req_cmd), req_time_stamp, req_frame_payload);
         pending_outcomes.insert(pending_outcomes.size(), new_res);
      end
   end

   // compare every accepted result with the oldest prediction
   always @(posedge clock) begin
      recorder_result_type exp_res;
      recorder_result_type got_res;
      if (!reset && rsp_valid && rsp_ready) begin
         got_res = '{rsp_frame_found, rsp_found_payload, rsp_was_stored, rsp_store_full,
                     rsp_entry_count};
         if (pending_outcomes.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected result with nothing pending: found=%0d payload=%h",
                        got_res.found, got_res.payload);
         end else begin
            exp_res = pending_outcomes.pop_front();
            if (got_res.found !== exp_res.found || got_res.payload !== exp_res.payload ||
                got_res.stored !== exp_res.stored || got_res.full !== exp_res.full ||
                got_res.count !== exp_res.count) begin
               failures++;
               if (failures <= 10) begin
                  $display("mismatch exp: found=%0d payload=%h stored=%0d full=%0d count=%0d",
                           exp_res.found, exp_res.payload, exp_res.stored, exp_res.full,
                           exp_res.count);
                  $display("         got: found=%0d payload=%h stored=%0d full=%0d count=%0d",
                           got_res.found, got_res.payload, got_res.stored, got_res.full,
                           got_res.count);
               end
            end
         end
      end
   end

   // receiver readiness
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("[timed_frame_recorder_core] ERROR");
         $finish;
      end
   end

   // send one request, with an optional idle gap in front
   task automatic send_request(input op_type op, input logic [TIME_W-1:0] stamp,
                               input logic [PAYLOAD_W-1:0] frame);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_valid         <= 1'b1;
      req_cmd           <= op;
      req_time_stamp    <= stamp;
      req_frame_payload <= frame;
      do @(posedge clock); while (!req_ready);
   endtask

   // hold off the sender until every result has come back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   // one random request: mostly ascending appends and lookups near stored times
   task automatic send_random_request();
      int unsigned          pick;
      logic [TIME_W-1:0]    stamp;
      logic [PAYLOAD_W-1:0] frame;
      pick  = $urandom_range(99);
      frame = PAYLOAD_W'({$urandom, $urandom});
      if (pick < 42) begin
         next_time += $urandom_range(1, 2000);
         if ($urandom_range(9) == 0 && shadow_count != 0)
            frame = shadow_payloads[shadow_count - 1];
         send_request(OP_APPEND, next_time, frame);
      end else if (pick < 50) begin
         // out-of-order time
         send_request(OP_APPEND, {$urandom, $urandom}, frame);
      end else begin
         pick = $urandom_range(9);
         if (pick < 6 && shadow_count != 0) begin
            stamp = shadow_times[$urandom_range(shadow_count - 1)];
            case ($urandom_range(2))
               0: stamp = stamp - 1;
               1: stamp = stamp + 1;
               default: ;
            endcase
         end else if (pick < 8) begin
            stamp = {$urandom, $urandom};
         end else begin
            stamp = (pick == 8) ? '0 : '1;
         end
         send_request(OP_LOOKUP, stamp, frame);
      end
   endtask

   // empty store, duplicates, query before all entries, extremes
   task automatic test_directed_cases();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      send_request(OP_LOOKUP, 64'd500, '1);
      send_request(OP_APPEND, 64'd100, '0);
      send_request(OP_APPEND, 64'd150, '0);
      send_request(OP_LOOKUP, '0, '0);
      send_request(OP_LOOKUP, '1, '0);
      send_request(OP_APPEND, 64'd200, '1);
      send_request(OP_APPEND, 64'd300, '1);
      send_request(OP_LOOKUP, 64'd199, '0);
      send_request(OP_LOOKUP, 64'd200, '0);
      send_request(OP_APPEND, 64'd300, 56'h12_3456_789a_bcde);
      send_request(OP_LOOKUP, 64'd99, '0);
      send_request(OP_LOOKUP, 64'd300, '0);
      send_request(OP_APPEND, 64'd50, 56'hed_cba9_8765_4321);
      send_request(OP_LOOKUP, 64'd60, '0);
      send_request(OP_LOOKUP, 64'd250, '0);
      send_request(OP_APPEND, '1, 56'haa_aaaa_aaaa_aaaa);
      send_request(OP_APPEND, '0, 56'h55_5555_5555_5555);
      send_request(OP_LOOKUP, '1, '1);
      send_request(OP_LOOKUP, 64'hffff_ffff_ffff_fffe, '1);
      send_request(OP_LOOKUP, '0, '1);
   endtask

   task automatic test_steady_flow();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      repeat (70) send_random_request();
   endtask

   // sparse sender, with one full drain in the middle
   task automatic test_sparse_requests();
      sender_idle_pct    = 85;
      receiver_stall_pct = 0;
      repeat (35) send_random_request();
      wait_for_drain();
      repeat (35) send_random_request();
   endtask

   task automatic test_slow_consumer();
      sender_idle_pct    = 0;
      receiver_stall_pct = 85;
      repeat (70) send_random_request();
   endtask

   task automatic test_mixed_idling();
      sender_idle_pct    = 22;
      receiver_stall_pct = 22;
      repeat (50) send_random_request();
   endtask

   // fill the store to the top, then drop appends and search the full store
   task automatic test_full_store();
      int unsigned          room;
      logic [PAYLOAD_W-1:0] last_frame;
      logic [PAYLOAD_W-1:0] frame;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      wait_for_drain();
      room       = DEPTH - shadow_count;
      last_frame = (shadow_count != 0) ? shadow_payloads[shadow_count - 1] : '0;
      repeat (room) begin
         frame = PAYLOAD_W'({$urandom, $urandom});
         if (frame == last_frame) frame[0] = ~frame[0];
         next_time += $urandom_range(1, 2000);
         send_request(OP_APPEND, next_time, frame);
         last_frame = frame;
      end
      send_request(OP_APPEND, next_time + 1, ~last_frame);
      send_request(OP_APPEND, next_time + 2, last_frame);
      send_request(OP_LOOKUP, '0, '0);
      send_request(OP_LOOKUP, '1, '0);
      sender_idle_pct    = 22;
      receiver_stall_pct = 22;
      repeat (40) send_random_request();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_steady_flow();
      test_sparse_requests();
      test_slow_consumer();
      test_mixed_idling();
      test_full_store();
      wait_for_drain();
      repeat (DRAIN_TAIL) @(posedge clock);
      if (pending_outcomes.size() != 0) begin
         failures += pending_outcomes.size();
         $display("%0d results never arrived", pending_outcomes.size());
      end
      if (failures == 0) begin
         $display("[timed_frame_recorder_core] OK");
      end else begin
         $display("[timed_frame_recorder_core] ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
design/tfr_pkg.sv
design/tfr_front.sv
design/tfr_queue.sv
design/tfr_back.sv
design/timed_frame_recorder_core.sv
test/timed_frame_recorder_core_test.sv
